FILE: rtl/u2u_pkg.sv
package u2u_pkg;

    localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
    localparam logic [20:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW     = 21'h00D800;
    localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [20:0] SUPPLEMENTAL = 21'h010000;
    localparam logic [20:0] LEAST_LEN2   = 21'h000080;
    localparam logic [20:0] LEAST_LEN3   = 21'h000800;
    localparam logic [15:0] HIGH_SURR    = 16'hD800;
    localparam logic [15:0] LOW_SURR     = 16'hDC00;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One decoded byte: some replacement units first, then up to two plain units.
    typedef struct packed {
        logic [2:0]  repl_cnt;
        logic [1:0]  tail_cnt;
        logic [15:0] tail0;
        logic [15:0] tail1;
        logic        last;
    } t_job;

endpackage

FILE: rtl/u2u_front.sv
module u2u_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_push,
    output u2u_pkg::t_job  o_job
);

    logic [2:0]  r_seq_len;
    logic [1:0]  r_cont_seen;
    logic [20:0] r_point;
    logic [2:0]  n_seq_len;
    logic [1:0]  n_cont_seen;
    logic [20:0] n_point;

    logic          pending;
    logic          is_cont;
    logic [2:0]    seen;
    logic [20:0]   point_new;
    logic [20:0]   least;
    logic [19:0]   offset;
    logic          bad_point;
    u2u_pkg::t_job job;

    assign pending   = (r_seq_len != u2u_pkg::LEN_NONE);
    assign is_cont   = (i_byte[7:6] == 2'b10);
    assign seen      = {1'b0, r_cont_seen} + 3'd1;
    assign point_new = {r_point[14:0], i_byte[5:0]};

    always_comb begin
        case (r_seq_len)
            u2u_pkg::LEN_TWO:   least = u2u_pkg::LEAST_LEN2;
            u2u_pkg::LEN_THREE: least = u2u_pkg::LEAST_LEN3;
            default:            least = u2u_pkg::SUPPLEMENTAL;
        endcase
    end

    assign bad_point = (point_new < least) || (point_new > u2u_pkg::MAX_POINT) ||
                       ((point_new >= u2u_pkg::SURR_LOW) && (point_new <= u2u_pkg::SURR_HIGH));
    assign offset    = point_new[19:0] - u2u_pkg::SUPPLEMENTAL[19:0];

    always_comb begin
        job         = '0;
        job.last    = i_last;
        n_seq_len   = r_seq_len;
        n_cont_seen = r_cont_seen;
        n_point     = r_point;

        if (pending && is_cont) begin
            if ((seen + 3'd1) >= r_seq_len) begin
                n_seq_len   = u2u_pkg::LEN_NONE;
                n_cont_seen = '0;
                n_point     = '0;
                if (bad_point) begin
                    job.repl_cnt = 3'd1;
                end else if (point_new[20:16] == 5'd0) begin
                    job.tail_cnt = 2'd1;
                    job.tail0    = point_new[15:0];
                end else begin
                    job.tail_cnt = 2'd2;
                    job.tail0    = u2u_pkg::HIGH_SURR + {6'd0, offset[19:10]};
                    job.tail1    = u2u_pkg::LOW_SURR + {6'd0, offset[9:0]};
                end
            end else if (i_last) begin
                job.repl_cnt = seen + 3'd1;
            end else begin
                n_cont_seen = seen[1:0];
                n_point     = point_new;
            end
        end else begin
            // A broken sequence flushes its lead and continuations before the
            // byte is decoded as a fresh one.
            if (pending) begin
                job.repl_cnt = seen;
            end
            n_seq_len   = u2u_pkg::LEN_NONE;
            n_cont_seen = '0;
            n_point     = '0;
            if (i_byte[7] == 1'b0) begin
                job.tail_cnt = 2'd1;
                job.tail0    = {8'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_seq_len = u2u_pkg::LEN_TWO;
                n_point   = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                n_seq_len = u2u_pkg::LEN_THREE;
                n_point   = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                n_seq_len = u2u_pkg::LEN_FOUR;
                n_point   = {18'd0, i_byte[2:0]};
            end else begin
                job.repl_cnt = job.repl_cnt + 3'd1;
            end
            if (i_last && (n_seq_len != u2u_pkg::LEN_NONE)) begin
                job.repl_cnt = job.repl_cnt + 3'd1;
            end
        end

        if (i_last) begin
            n_seq_len   = u2u_pkg::LEN_NONE;
            n_cont_seen = '0;
            n_point     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= u2u_pkg::LEN_NONE;
            r_cont_seen <= '0;
            r_point     <= '0;
        end else if (i_accept) begin
            r_seq_len   <= n_seq_len;
            r_cont_seen <= n_cont_seen;
            r_point     <= n_point;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && ((job.repl_cnt != 3'd0) || (job.tail_cnt != 2'd0));

endmodule

FILE: rtl/u2u_queue.sv
module u2u_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u2u_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output u2u_pkg::t_job  o_job
);

    u2u_pkg::t_job                  r_mem [u2u_pkg::QUEUE_DEPTH];
    logic [u2u_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [u2u_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [u2u_pkg::QUEUE_CW-1:0]   r_count;

    assign o_full  = (r_count == u2u_pkg::QUEUE_CW'(u2u_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == u2u_pkg::QUEUE_AW'(u2u_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == u2u_pkg::QUEUE_AW'(u2u_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/u2u_back.sv
module u2u_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  u2u_pkg::t_job  i_job,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [15:0]    o_code_unit,
    output logic           o_run_end,
    output logic           o_string_end
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [15:0] r_code_unit;
    logic        r_run_end;
    logic        r_string_end;

    logic        load;
    logic [2:0]  total;
    logic [2:0]  idx_ext;
    logic [2:0]  tail_pos;
    logic        last_unit;
    logic [15:0] unit;

    assign load      = i_valid && (!r_valid || i_ready);
    assign total     = i_job.repl_cnt + {1'b0, i_job.tail_cnt};
    assign idx_ext   = {1'b0, r_idx};
    assign tail_pos  = idx_ext - i_job.repl_cnt;
    assign last_unit = (idx_ext == (total - 3'd1));

    always_comb begin
        if (idx_ext < i_job.repl_cnt) begin
            unit = u2u_pkg::REPLACEMENT;
        end else if (tail_pos[0] == 1'b0) begin
            unit = i_job.tail0;
        end else begin
            unit = i_job.tail1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_unit ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code_unit  <= unit;
            r_run_end    <= last_unit;
            r_string_end <= last_unit && i_job.last;
        end
    end

    assign o_pop        = load && last_unit;
    assign o_valid      = r_valid;
    assign o_code_unit  = r_code_unit;
    assign o_run_end    = r_run_end;
    assign o_string_end = r_string_end;

endmodule

FILE: rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder with U+FFFD replacement.
// Slave channel: one UTF-8 byte per word in tdata, tlast set on the final byte
// of a string. Master channel: one UTF-16 code unit per word in tdata, tuser set
// on the last unit caused by an input byte, tlast on the final unit of a string.
// A front stage decodes each accepted byte against the pending sequence state and
// writes a job (replacement count plus up to two plain units) into a two-entry
// queue; a back stage expands each job into code units through an output register.
// Each byte's job is registered in the queue and each of its units in the output
// register before the unit is offered on the master side.
// Throughput: one byte per cycle while each byte yields at most one unit and the
// master side is ready; the back stage emits one unit per cycle unless stalled, and
// a job leaves the queue with its last unit; tready falls once both entries are used.
// Lead and middle bytes of a multibyte sequence yield no word unless they end a string.
// Reset (synchronous, active low) clears the sequence state, the queue and the
// output register. A stall on the master side holds the output word and fills the
// queue; the slave side then stalls, and no word is lost or repeated.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] input_byte
    input  logic        i_s_axis_tlast,   // last_in_string
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic        o_m_axis_tuser,   // [0] run_end
    output logic        o_m_axis_tlast    // string_end
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    u2u_pkg::t_job front_job;
    u2u_pkg::t_job head_job;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    u2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (push),
        .o_job    (front_job)
    );

    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    u2u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .i_ready      (i_m_axis_tready),
        .o_valid      (o_m_axis_tvalid),
        .o_code_unit  (o_m_axis_tdata),
        .o_run_end    (o_m_axis_tuser),
        .o_string_end (o_m_axis_tlast)
    );

endmodule

FILE: rtl/u2u_checker.sv
module u2u_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata,
    input  logic        o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    // The end of a string is always the end of a byte's run.
    a_string_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("string end without run end");

    // A high surrogate is always followed by its low half from the same byte.
    a_high_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[15:10] == 6'b110110) |-> !o_m_axis_tuser)
        else $error("high surrogate ends a run");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_u2u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

FILE: test/utf8_to_utf16_transcoder_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [15:0] value;
    logic        run_end;
    logic        string_end;
} t_code_unit;

typedef struct packed {
    logic       last;
    logic [7:0] data;
} t_text_byte;

// Tracks the pending UTF-8 sequence and holds the code units still owed by the block.
class utf16_scoreboard;
    logic [2:0]  seq_len;
    logic [1:0]  conts_seen;
    logic [20:0] point;
    t_code_unit  due_units [$];
    t_code_unit  step_units [$];

    function new();
        clear_sequence();
    endfunction

    function void clear_sequence();
        seq_len    = u2u_pkg::LEN_NONE;
        conts_seen = 2'd0;
        point      = 21'd0;
    endfunction

    function void add_unit(logic [15:0] value);
        t_code_unit u;
        u.value      = value;
        u.run_end    = 1'b0;
        u.string_end = 1'b0;
        step_units.push_back(u);
    endfunction

    function void add_replacements(int count);
        repeat (count) add_unit(u2u_pkg::REPLACEMENT);
    endfunction

    function void finish_point();
        logic [20:0] floor_value;
        logic [20:0] offset;
        floor_value = (seq_len == u2u_pkg::LEN_TWO)   ? u2u_pkg::LEAST_LEN2 :
                      (seq_len == u2u_pkg::LEN_THREE) ? u2u_pkg::LEAST_LEN3 :
                      u2u_pkg::SUPPLEMENTAL;
        if (point < floor_value || point > u2u_pkg::MAX_POINT ||
                (point >= u2u_pkg::SURR_LOW && point <= u2u_pkg::SURR_HIGH)) begin
            add_unit(u2u_pkg::REPLACEMENT);
        end else if (point < u2u_pkg::SUPPLEMENTAL) begin
            add_unit(point[15:0]);
        end else begin
            offset = point - u2u_pkg::SUPPLEMENTAL;
            add_unit(u2u_pkg::HIGH_SURR + {6'd0, offset[19:10]});
            add_unit(u2u_pkg::LOW_SURR + {6'd0, offset[9:0]});
        end
    endfunction

    // Decode a byte as if no sequence were pending.
    function void start_fresh(logic [7:0] b, logic last);
        logic is_lead;
        is_lead = 1'b1;
        if (!b[7]) begin
            add_unit({8'h00, b});
            is_lead = 1'b0;
        end else if (b[7:5] == 3'b110) begin
            seq_len = u2u_pkg::LEN_TWO;
            point   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            seq_len = u2u_pkg::LEN_THREE;
            point   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            seq_len = u2u_pkg::LEN_FOUR;
            point   = {18'd0, b[2:0]};
        end else begin
            add_unit(u2u_pkg::REPLACEMENT);
            is_lead = 1'b0;
        end
        if (is_lead) begin
            conts_seen = 2'd0;
            if (last) begin
                add_unit(u2u_pkg::REPLACEMENT);
                clear_sequence();
            end
        end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
        int seen;
        step_units.delete();
        if (seq_len >= u2u_pkg::LEN_TWO && seq_len <= u2u_pkg::LEN_FOUR) begin
            if (b[7:6] == 2'b10) begin
                seen  = conts_seen + 1;
                point = {point[14:0], b[5:0]};
                if (seen + 1 >= seq_len) begin
                    finish_point();
                    clear_sequence();
                end else if (last) begin
                    add_replacements(seen + 1);
                    clear_sequence();
                end else begin
                    conts_seen = seen[1:0];
                end
            end else begin
                // Broken sequence: one replacement per byte collected, then decode anew.
                add_replacements(conts_seen + 1);
                clear_sequence();
                start_fresh(b, last);
            end
        end else begin
            clear_sequence();
            start_fresh(b, last);
        end
        if (last)
            clear_sequence();
        if (step_units.size() > 0) begin
            step_units[step_units.size() - 1].run_end    = 1'b1;
            step_units[step_units.size() - 1].string_end = last;
        end
        foreach (step_units[k])
            due_units.push_back(step_units[k]);
    endfunction

    function int outstanding();
        return due_units.size();
    endfunction

    function int check_unit(logic [15:0] value, logic run_end, logic string_end,
                            output string why);
        t_code_unit want;
        int bad;
        bad = 0;
        why = "";
        if (due_units.size() == 0) begin
            why = $sformatf("unexpected code unit %h", value);
            return 1;
        end
        want = due_units.pop_front();
        if (value !== want.value) begin
            why = {why, $sformatf(" code_unit %h want %h", value, want.value)};
            bad++;
        end
        if (run_end !== want.run_end) begin
            why = {why, $sformatf(" run_end %b want %b", run_end, want.run_end)};
            bad++;
        end
        if (string_end !== want.string_end) begin
            why = {why, $sformatf(" string_end %b want %b", string_end, want.string_end)};
            bad++;
        end
        return bad;
    endfunction
endclass

module utf8_to_utf16_transcoder_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] input_byte
    logic        i_s_axis_tlast;   // last_in_string
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [15:0] code_unit
    logic        o_m_axis_tuser;   // [0] run_end
    logic        o_m_axis_tlast;   // string_end

    utf16_scoreboard sb = new();

    t_text_byte text_bytes [$];
    int mismatch_count = 0;
    int hold_request = 0;
    bit sender_steady = 1'b0;
    bit receiver_steady = 1'b0;

    // Plain text, extremes, a surrogate pair, overlong, surrogate and too-large
    // forms, invalid and stray bytes, a broken and a truncated sequence.
    t_text_byte directed_text [$] = '{
        9'h000, 9'h07F,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
        9'h0C0, 9'h080,
        9'h0ED, 9'h0A0, 9'h080,
        9'h0F8, 9'h0BF,
        9'h0E2, 9'h041,
        9'h0F0, 9'h09F, 9'h098, 9'h1C3,
        9'h0F5, 9'h080, 9'h080, 9'h180
    };

    utf8_to_utf16_transcoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string why);
        mismatch_count++;
        $display("mismatch at %0t:%s", $time, why);
    endtask

    function automatic void add_text_byte(logic [7:0] b);
        t_text_byte w;
        w.data = b;
        w.last = ($urandom_range(11) == 0);
        text_bytes.push_back(w);
    endfunction

    function automatic logic [7:0] random_lead(int len);
        if (len == 2)
            return 8'hC0 | 8'($urandom_range(31));
        if (len == 3)
            return 8'hE0 | 8'($urandom_range(15));
        // Mostly leads up to F4, sometimes the too-large F5..F7.
        if ($urandom_range(3) == 0)
            return 8'hF0 | 8'($urandom_range(7));
        return 8'hF0 | 8'($urandom_range(4));
    endfunction

    function automatic void add_random_text(int count);
        int kind;
        int len;
        int kept;
        while (text_bytes.size() < count) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                add_text_byte(8'($urandom_range(127)));
            end else if (kind < 70) begin
                len = $urandom_range(2, 4);
                add_text_byte(random_lead(len));
                repeat (len - 1) add_text_byte(8'h80 | 8'($urandom_range(63)));
            end else if (kind < 85) begin
                // Sequence cut short by a plain byte or by a byte from C0 to FF (a new lead or invalid).
                len  = $urandom_range(2, 4);
                kept = $urandom_range(len - 2);
                add_text_byte(random_lead(len));
                repeat (kept) add_text_byte(8'h80 | 8'($urandom_range(63)));
                if ($urandom_range(1) == 0)
                    add_text_byte(8'($urandom_range(127)));
                else
                    add_text_byte(8'hC0 | 8'($urandom_range(63)));
            end else begin
                add_text_byte(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic send_text();
        t_text_byte w;
        while (text_bytes.size() > 0) begin
            w = text_bytes.pop_front();
            while (!sender_steady && $urandom_range(99) < 27) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= w.data;
            i_s_axis_tlast  <= w.last;
            do @(posedge i_clk); while (!o_s_axis_tready);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Always waits at least one edge, so valid is never lowered and raised in one step.
    task automatic drain_results(input int limit);
        int waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.outstanding() != 0 && waited < limit);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= receiver_steady || ($urandom_range(99) >= 27);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.take_byte(i_s_axis_tdata, i_s_axis_tlast);
    end

    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (sb.check_unit(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast, why) != 0)
                report_mismatch(why);
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_s_axis_tlast  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words with no idling on either side.
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        text_bytes      = directed_text;
        send_text();
        drain_results(5000);

        // Receiver holds off while the sender keeps offering words.
        receiver_steady = 1'b0;
        hold_request    = 80;
        add_random_text(30);
        send_text();
        drain_results(5000);

        sender_steady = 1'b0;
        add_random_text(114);
        text_bytes[text_bytes.size() - 1].last = 1'b1;
        send_text();
        drain_results(5000);
        repeat (10) @(posedge i_clk);

        if (sb.outstanding() != 0)
            report_mismatch($sformatf(" %0d code units never arrived", sb.outstanding()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
